[hw/rtl/deqs_pkg.sv]
// Shared types and codes for the bounded double-ended queue with search.
`default_nettype none

package deqs_pkg;

	// Request codes
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_SEARCH     = 3'd4;

	// Result status codes
	localparam logic [1:0] STS_DONE       = 2'd0;
	localparam logic [1:0] STS_FULL_DROP  = 2'd1;
	localparam logic [1:0] STS_EMPTY_POP  = 2'd2;

	typedef struct packed {
		logic        [2:0]  req_type;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [3:0] match_position;
		logic       is_empty;
		logic [4:0] entry_total;
	} rsp_t;

endpackage

`default_nettype wire

[hw/rtl/double_ended_queue_search.sv]
// Bounded double-ended queue with linear search: top level.
// Holds up to DEPTH values of DATA_WIDTH bits in a ring buffer kept in one
// memory (one write and one registered read port), addressed from a front
// index. Pushes, pops and unused request codes finish in the transfer cycle
// and the result is presented on the next cycle. A search walks the held
// entries from the front through the single read port and one comparator,
// one entry per cycle unless the result output is stalled, and finishes on
// the first match or after the last held entry; the block takes no new request
// while a search runs. Only the low DATA_WIDTH bits of a value are stored and
// compared. Status and counts are reported truncated to the result fields.
`default_nettype none

module double_ended_queue_search #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  deqs_pkg::req_t   req,
	output logic             rsp_valid,
	input  wire              rsp_stall,
	output deqs_pkg::rsp_t   rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;

	localparam logic [0:0] ST_IDLE   = 1'b0;
	localparam logic [0:0] ST_SEARCH = 1'b1;

	logic [0:0]            state_q, state_d;
	logic [AW-1:0]         front_q, front_d;
	logic [CW-1:0]         occ_q, occ_d;
	logic [CW-1:0]         iss_q, iss_d;
	logic [DATA_WIDTH-1:0] key_q;
	logic [DATA_WIDTH-1:0] store_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_s1;
	logic                  rd_vld_s1, rd_vld_d;
	logic [AW-1:0]         pos_s1;
	logic                  rsp_valid_q;
	deqs_pkg::rsp_t        rsp_q, rsp_d;

	logic                  advance, acc, load_rsp, hit;
	logic                  wr_en, rd_en, load_key;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] in_val;
	logic [CW-1:0]         ring_off;
	logic [SW-1:0]         ring_sum;
	logic [AW-1:0]         ring_addr, front_dec, front_inc;
	logic                  is_full, is_empty_now;

	// Output register frees up when empty or drained this cycle
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !advance;
	assign acc       = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign in_val       = DATA_WIDTH'(req.value);
	assign is_full      = (occ_q == CW'(DEPTH));
	assign is_empty_now = (occ_q == '0);
	assign hit          = rd_vld_s1 && (rd_data_s1 == key_q);

	// Shared ring adder: back slot on push back, walk slot while searching
	assign ring_off  = (state_q == ST_SEARCH) ? iss_q : occ_q;
	assign ring_sum  = SW'(front_q) + SW'(ring_off);
	assign ring_addr = (ring_sum >= SW'(DEPTH)) ? AW'(ring_sum - SW'(DEPTH)) : AW'(ring_sum);

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

	// Request decode and search sequencer
	always_comb begin
		state_d  = state_q;
		front_d  = front_q;
		occ_d    = occ_q;
		iss_d    = iss_q;
		rd_vld_d = rd_vld_s1;
		wr_en    = 1'b0;
		wr_addr  = ring_addr;
		rd_en    = 1'b0;
		load_key = 1'b0;
		load_rsp = 1'b0;
		rsp_d    = '0;

		if (state_q == ST_IDLE) begin
			if (acc) begin
				load_rsp = 1'b1;
				case (req.req_type)
					deqs_pkg::REQ_PUSH_FRONT: begin
						if (is_full) begin
							rsp_d.status = deqs_pkg::STS_FULL_DROP;
						end else begin
							front_d = front_dec;
							wr_en   = 1'b1;
							wr_addr = front_dec;
							occ_d   = occ_q + CW'(1);
						end
					end
					deqs_pkg::REQ_PUSH_BACK: begin
						if (is_full) begin
							rsp_d.status = deqs_pkg::STS_FULL_DROP;
						end else begin
							wr_en = 1'b1;
							occ_d = occ_q + CW'(1);
						end
					end
					deqs_pkg::REQ_POP_FRONT: begin
						if (is_empty_now) begin
							rsp_d.status = deqs_pkg::STS_EMPTY_POP;
						end else begin
							front_d = front_inc;
							occ_d   = occ_q - CW'(1);
						end
					end
					deqs_pkg::REQ_POP_BACK: begin
						if (is_empty_now) begin
							rsp_d.status = deqs_pkg::STS_EMPTY_POP;
						end else begin
							occ_d = occ_q - CW'(1);
						end
					end
					deqs_pkg::REQ_SEARCH: begin
						load_rsp = 1'b0;
						load_key = 1'b1;
						iss_d    = '0;
						rd_vld_d = 1'b0;
						state_d  = ST_SEARCH;
					end
					default: begin
					end
				endcase
				rsp_d.is_empty    = (occ_d == '0);
				rsp_d.entry_total = 5'(occ_d);
			end
		end else if (advance) begin
			// Compare the entry from the last issued read; finish on a hit or at the end, else read the next
			rsp_d.is_empty    = is_empty_now;
			rsp_d.entry_total = 5'(occ_q);
			if (hit) begin
				rsp_d.found          = 1'b1;
				rsp_d.match_position = 4'(pos_s1);
				load_rsp             = 1'b1;
				rd_vld_d             = 1'b0;
				state_d              = ST_IDLE;
			end else if (iss_q == occ_q) begin
				load_rsp = 1'b1;
				rd_vld_d = 1'b0;
				state_d  = ST_IDLE;
			end else begin
				rd_en    = 1'b1;
				rd_vld_d = 1'b1;
				iss_d    = iss_q + CW'(1);
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			occ_q       <= '0;
			iss_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			front_q   <= front_d;
			occ_q     <= occ_d;
			iss_q     <= iss_d;
			rd_vld_s1 <= rd_vld_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
		if (load_key) begin
			key_q <= in_val;
		end
		if (rd_en) begin
			pos_s1 <= AW'(iss_q);
		end
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= in_val;
		end
		if (rd_en) begin
			rd_data_s1 <= store_q[ring_addr];
		end
	end

	// Occupancy never exceeds the ring size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above DEPTH");

	// A pop on a nonempty queue removes exactly one entry
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !is_empty_now && (req.req_type == deqs_pkg::REQ_POP_FRONT ||
		req.req_type == deqs_pkg::REQ_POP_BACK)) |=> (occ_q == $past(occ_q) - CW'(1)))
		else $error("pop did not decrement occupancy");

	// The entry under compare is always a held one
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH && rd_vld_s1) |-> (CW'(pos_s1) < occ_q))
		else $error("search compared beyond held entries");

	// A reported match comes with done status on a nonempty queue
	a_match_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |->
		(rsp.status == deqs_pkg::STS_DONE && !rsp.is_empty))
		else $error("match reported on empty queue or with error status");

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the bounded double-ended queue with search.
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH = 16;
	localparam logic [4:0] FULL_COUNT = 5'd16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	deqs_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	deqs_pkg::rsp_t rsp;

	double_ended_queue_search #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(32)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the deque contents
	logic [31:0] shadow_store [DEPTH];
	logic [3:0]  shadow_front = '0;
	logic [4:0]  shadow_count = '0;

	deqs_pkg::rsp_t pending_rsp [$];
	int mismatches = 0;
	bit idle_on = 1'b1;

	// Tallies for the closing summary
	int n_push = 0, n_push_drop = 0, n_pop = 0, n_pop_empty = 0;
	int n_hit = 0, n_miss = 0, n_unused = 0, n_results = 0;

	// Apply one request to the shadow deque and return the result it should give
	function automatic deqs_pkg::rsp_t deque_apply(deqs_pkg::req_t r);
		deqs_pkg::rsp_t res;
		logic [3:0] slot;
		res = '0;
		case (r.req_type)
			deqs_pkg::REQ_PUSH_FRONT, deqs_pkg::REQ_PUSH_BACK: begin
				if (shadow_count == FULL_COUNT) begin
					res.status = deqs_pkg::STS_FULL_DROP;
				end else if (r.req_type == deqs_pkg::REQ_PUSH_FRONT) begin
					shadow_front = shadow_front - 4'd1;
					shadow_store[shadow_front] = r.value;
					shadow_count = shadow_count + 5'd1;
				end else begin
					slot = shadow_front + shadow_count[3:0];
					shadow_store[slot] = r.value;
					shadow_count = shadow_count + 5'd1;
				end
			end
			deqs_pkg::REQ_POP_FRONT, deqs_pkg::REQ_POP_BACK: begin
				if (shadow_count == 5'd0) begin
					res.status = deqs_pkg::STS_EMPTY_POP;
				end else begin
					if (r.req_type == deqs_pkg::REQ_POP_FRONT)
						shadow_front = shadow_front + 4'd1;
					shadow_count = shadow_count - 5'd1;
				end
			end
			deqs_pkg::REQ_SEARCH: begin
				// first match from the front wins
				for (int i = 0; i < shadow_count; i++) begin
					slot = shadow_front + i[3:0];
					if (!res.found && shadow_store[slot] == r.value) begin
						res.found = 1'b1;
						res.match_position = i[3:0];
					end
				end
			end
			default: ;
		endcase
		res.is_empty = (shadow_count == 5'd0);
		res.entry_total = shadow_count;
		return res;
	endfunction

	// Count what kind of request this was
	function automatic void tally(deqs_pkg::req_t r, deqs_pkg::rsp_t res);
		case (r.req_type)
			deqs_pkg::REQ_PUSH_FRONT, deqs_pkg::REQ_PUSH_BACK:
				if (res.status == deqs_pkg::STS_FULL_DROP) n_push_drop++; else n_push++;
			deqs_pkg::REQ_POP_FRONT, deqs_pkg::REQ_POP_BACK:
				if (res.status == deqs_pkg::STS_EMPTY_POP) n_pop_empty++; else n_pop++;
			deqs_pkg::REQ_SEARCH:
				if (res.found) n_hit++; else n_miss++;
			default:
				n_unused++;
		endcase
	endfunction

	// Drive one request and wait for its transfer
	task automatic send_request(input logic [2:0] code, input logic [31:0] val);
		deqs_pkg::req_t item;
		deqs_pkg::rsp_t res;
		int gap;
		item.req_type = code;
		item.value = val;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				req_valid <= 1'b0;
			end
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		res = deque_apply(item);
		tally(item, res);
		pending_rsp.push_back(res);
	endtask

	// Hold off until every outstanding result is back
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Random receiver stall bursts, started only while idle_on is set
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			rsp_stall <= 1'b1;
			stall_left = $urandom_range(1, 3) - 1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin : rsp_check
		deqs_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, rsp);
				mismatches++;
			end else begin
				want = pending_rsp.pop_front();
				n_results++;
				check_field("status", want.status, rsp.status);
				check_field("found", want.found, rsp.found);
				check_field("match_position", want.match_position, rsp.match_position);
				check_field("is_empty", want.is_empty, rsp.is_empty);
				check_field("entry_total", want.entry_total, rsp.entry_total);
			end
		end
	end

	// Values biased toward extremes and a small pool so searches hit duplicates
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4, 5, 6: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// Mostly a held value, otherwise anything
	function automatic logic [31:0] search_value();
		logic [3:0] slot;
		if (shadow_count != 5'd0 && $urandom_range(0, 2) != 0) begin
			slot = shadow_front + 4'($urandom_range(0, shadow_count - 1));
			return shadow_store[slot];
		end
		return pick_value();
	endfunction

	task automatic test_empty_requests();
		send_request(deqs_pkg::REQ_POP_FRONT, 32'h1234_5678);
		send_request(deqs_pkg::REQ_POP_BACK, 32'hffff_ffff);
		send_request(deqs_pkg::REQ_SEARCH, 32'h0000_0000);
	endtask

	task automatic test_extreme_values();
		// front to back: -1, min, max, 0
		send_request(deqs_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
		send_request(deqs_pkg::REQ_PUSH_BACK, 32'h7fff_ffff);
		send_request(deqs_pkg::REQ_PUSH_BACK, 32'h0000_0000);
		send_request(deqs_pkg::REQ_PUSH_FRONT, 32'hffff_ffff);
		send_request(deqs_pkg::REQ_SEARCH, 32'h7fff_ffff);
		send_request(deqs_pkg::REQ_SEARCH, 32'h0000_0000);
		send_request(deqs_pkg::REQ_SEARCH, 32'hffff_ffff);
		send_request(deqs_pkg::REQ_SEARCH, 32'h0000_0005);
	endtask

	task automatic test_unused_codes();
		send_request(3'd5, 32'hffff_ffff);
		send_request(3'd6, 32'h0000_0000);
		send_request(3'd7, 32'h7fff_ffff);
	endtask

	task automatic test_full_requests();
		// fill with alternating threes and zeros, last entry unique
		for (int i = 0; i < 11; i++)
			send_request(deqs_pkg::REQ_PUSH_BACK, (i % 2) ? 32'h0000_0000 : 32'h0000_0003);
		send_request(deqs_pkg::REQ_PUSH_BACK, 32'h5a5a_5a5a);
		send_request(deqs_pkg::REQ_PUSH_FRONT, 32'h0000_0001);
		send_request(deqs_pkg::REQ_PUSH_BACK, 32'h0000_0002);
		send_request(deqs_pkg::REQ_SEARCH, 32'h5a5a_5a5a);
		send_request(deqs_pkg::REQ_SEARCH, 32'h0000_0000);
	endtask

	task automatic test_random_walk(input int count, input bit allow_idle_toggle);
		int roll;
		logic [2:0] code;
		logic [31:0] val;
		bit fill_mode;
		fill_mode = 1'b0;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 39) == 0)
				fill_mode = !fill_mode;
			if (shadow_count == FULL_COUNT && fill_mode && $urandom_range(0, 3) == 0)
				fill_mode = 1'b0;
			if (shadow_count == 5'd0 && !fill_mode && $urandom_range(0, 3) == 0)
				fill_mode = 1'b1;
			if (allow_idle_toggle && $urandom_range(0, 63) == 0)
				idle_on = !idle_on;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				code = 3'($urandom_range(5, 7));
			else if (roll < 25)
				code = deqs_pkg::REQ_SEARCH;
			else if ((roll < 80) == fill_mode)
				code = $urandom_range(0, 1) ? deqs_pkg::REQ_PUSH_FRONT : deqs_pkg::REQ_PUSH_BACK;
			else
				code = $urandom_range(0, 1) ? deqs_pkg::REQ_POP_FRONT : deqs_pkg::REQ_POP_BACK;
			if (code == deqs_pkg::REQ_SEARCH)
				val = search_value();
			else if (code == deqs_pkg::REQ_PUSH_FRONT || code == deqs_pkg::REQ_PUSH_BACK)
				val = pick_value();
			else
				val = $urandom;
			send_request(code, val);
		end
	endtask

	// Main sequence
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_requests();
		test_extreme_values();
		test_unused_codes();
		test_full_requests();
		wait_drained();
		test_random_walk(400, 1'b1);
		wait_drained();
		test_random_walk(330, 1'b1);
		idle_on = 1'b0;
		test_random_walk(290, 1'b0);
		@(negedge clk);
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_rsp.size());
			mismatches++;
		end

		$display("Covered %0d pushes, %0d full drops, %0d pops, %0d empty pops,",
			n_push, n_push_drop, n_pop, n_pop_empty);
		$display("%0d search hits, %0d misses, %0d unused codes; %0d results checked",
			n_hit, n_miss, n_unused, n_results);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("%0t: timeout", $time);
		$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/deqs_pkg.sv
hw/rtl/double_ended_queue_search.sv
test/testbench.sv
